// ===== hw/rtl/ecs_pkg.sv =====
package ecs_pkg;

    localparam int MAX_FLOOR_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FLOOR_W         = 5;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_CABIN = 2'd1;
    localparam logic [1:0] KIND_HALL  = 2'd2;

    localparam logic [1:0] ACT_IDLE = 2'd0;
    localparam logic [1:0] ACT_PASS = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;
    localparam logic [1:0] ACT_CALL = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FLOOR_W-1:0] call_floor;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         action;
        logic [FLOOR_W-1:0] floor;
        logic               call_dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POPC_W, S_POPH_W, S_REMC, S_REMC_W, S_REMH_W,
        S_ARRIVE, S_NPC_W, S_NPH_W, S_STEP, S_FIN
    } t_state;

    typedef enum logic [1:0] {Q_IDLE, Q_SCAN, Q_SHIFT} t_qphase;

    typedef struct packed {
        logic       load_in;
        logic       push_c;
        logic       push_h;
        logic       pop_c;
        logic       pop_h;
        logic       rem_c;
        logic       rem_h;
        logic       goal_c;
        logic       goal_h;
        logic       goal_clr;
        logic       step;
        logic       load_out;
        logic [1:0] act;
        logic       dropped;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       floor_ok;
        logic       c_full;
        logic       h_full;
        logic       goal_zero;
        logic       arrived;
        logic       c_done;
        logic       c_hit;
        logic       h_done;
        logic       h_hit;
        logic       out_free;
    } t_sts;

endpackage

// ===== hw/rtl/ecs_queue.sv =====
module ecs_queue #(
    parameter int DEPTH = ecs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [ecs_pkg::FLOOR_W-1:0] i_push_data,
    input  logic                        i_find,
    input  logic                        i_head_only,
    input  logic [ecs_pkg::FLOOR_W-1:0] i_key,
    output logic                        o_full,
    output logic                        o_done,
    output logic                        o_hit,
    output logic [ecs_pkg::FLOOR_W-1:0] o_head
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [ecs_pkg::FLOOR_W-1:0] r_mem [DEPTH];
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_idx;
    ecs_pkg::t_qphase            r_phase;
    logic                        r_head_only;
    logic [ecs_pkg::FLOOR_W-1:0] r_key;
    logic                        r_done;
    logic                        r_hit;
    logic [ecs_pkg::FLOOR_W-1:0] r_head;
    logic [IW-1:0]               rd_addr;
    logic [ecs_pkg::FLOOR_W-1:0] rd_data;
    logic                        idx_in;
    logic                        next_in;

    assign idx_in  = r_idx < r_count;
    assign next_in = (r_idx + CW'(1)) < r_count;
    assign rd_addr = (r_phase == ecs_pkg::Q_SHIFT) ? r_idx[IW-1:0] + IW'(1) : r_idx[IW-1:0];
    assign rd_data = r_mem[rd_addr];
    assign o_full  = r_count == CW'(DEPTH);
    assign o_done  = r_done;
    assign o_hit   = r_hit;
    assign o_head  = r_head;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_count[IW-1:0]] <= i_push_data;
        end else if (r_phase == ecs_pkg::Q_SHIFT && next_in) begin
            r_mem[r_idx[IW-1:0]] <= rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= ecs_pkg::Q_IDLE;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                ecs_pkg::Q_IDLE: begin
                    if (i_push && !o_full) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (i_find) begin
                        r_idx       <= '0;
                        r_key       <= i_key;
                        r_head_only <= i_head_only;
                        r_phase     <= ecs_pkg::Q_SCAN;
                    end
                end
                ecs_pkg::Q_SCAN: begin
                    if (!idx_in) begin
                        r_done  <= 1'b1;
                        r_hit   <= 1'b0;
                        r_phase <= ecs_pkg::Q_IDLE;
                    end else if (r_head_only || rd_data == r_key) begin
                        r_head  <= rd_data;
                        r_phase <= ecs_pkg::Q_SHIFT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ecs_pkg::Q_SHIFT: begin
                    if (next_in) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_done  <= 1'b1;
                        r_hit   <= 1'b1;
                        r_phase <= ecs_pkg::Q_IDLE;
                    end
                end
                default: r_phase <= ecs_pkg::Q_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/ecs_dp.sv =====
module ecs_dp #(
    parameter int MAX_FLOOR   = ecs_pkg::MAX_FLOOR_DEF,
    parameter int QUEUE_DEPTH = ecs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ecs_pkg::t_cmd               i_cmd,
    output ecs_pkg::t_sts               o_sts,
    input  ecs_pkg::t_in_item           i_item,
    input  logic                        i_cfg_we,
    input  logic [ecs_pkg::FLOOR_W-1:0] i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output ecs_pkg::t_out_item          o_out_item
);
    localparam int FW = ecs_pkg::FLOOR_W;

    ecs_pkg::t_in_item  r_in;
    logic [FW-1:0]      r_pos;
    logic [FW-1:0]      r_goal;
    logic               r_ovalid;
    ecs_pkg::t_out_item r_out;
    logic [FW-1:0]      n_pos;
    logic [FW-1:0]      cfg_floor;
    logic               c_full, h_full, c_done, h_done, c_hit, h_hit;
    logic [FW-1:0]      c_head, h_head;

    ecs_queue #(.DEPTH(QUEUE_DEPTH)) u_cabin (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_cmd.push_c), .i_push_data(r_in.call_floor),
        .i_find(i_cmd.pop_c | i_cmd.rem_c), .i_head_only(i_cmd.pop_c), .i_key(r_pos),
        .o_full(c_full), .o_done(c_done), .o_hit(c_hit), .o_head(c_head)
    );

    ecs_queue #(.DEPTH(QUEUE_DEPTH)) u_hall (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_cmd.push_h), .i_push_data(r_in.call_floor),
        .i_find(i_cmd.pop_h | i_cmd.rem_h), .i_head_only(i_cmd.pop_h), .i_key(r_pos),
        .o_full(h_full), .o_done(h_done), .o_hit(h_hit), .o_head(h_head)
    );

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_floor = FW'(1);
        end else if (32'(i_cfg_data) > MAX_FLOOR) begin
            cfg_floor = FW'(MAX_FLOOR);
        end else begin
            cfg_floor = i_cfg_data;
        end
        if (r_pos < r_goal) begin
            n_pos = r_pos + FW'(1);
        end else if (r_pos > r_goal) begin
            n_pos = r_pos - FW'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_comb begin
        o_sts.kind      = r_in.kind;
        o_sts.floor_ok  = (r_in.call_floor != '0) && (32'(r_in.call_floor) <= MAX_FLOOR);
        o_sts.c_full    = c_full;
        o_sts.h_full    = h_full;
        o_sts.goal_zero = r_goal == '0;
        o_sts.arrived   = r_goal == r_pos;
        o_sts.c_done    = c_done;
        o_sts.c_hit     = c_hit;
        o_sts.h_done    = h_done;
        o_sts.h_hit     = h_hit;
        o_sts.out_free  = !(r_ovalid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_item;
        end
        if (i_cmd.load_out) begin
            r_out.action       <= i_cmd.act;
            r_out.floor        <= r_pos;
            r_out.call_dropped <= i_cmd.dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= FW'(1);
            r_goal   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pos <= cfg_floor;
            end else if (i_cmd.step) begin
                r_pos <= n_pos;
            end
            if (i_cmd.goal_c) begin
                r_goal <= c_head;
            end else if (i_cmd.goal_h) begin
                r_goal <= h_head;
            end else if (i_cmd.goal_clr) begin
                r_goal <= '0;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
endmodule

// ===== hw/rtl/ecs_ctrl.sv =====
module ecs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ecs_pkg::t_sts i_sts,
    output ecs_pkg::t_cmd o_cmd
);
    ecs_pkg::t_state r_state, n_state;
    logic            r_hit, n_hit;
    logic            r_arr, n_arr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecs_pkg::S_IDLE;
            r_hit   <= 1'b0;
            r_arr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            r_arr   <= n_arr;
        end
    end

    assign o_stall = r_state != ecs_pkg::S_IDLE;

    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        n_arr   = r_arr;
        o_cmd   = '0;
        o_cmd.act = (r_hit || r_arr) ? ecs_pkg::ACT_STOP : ecs_pkg::ACT_PASS;
        case (r_state)
            ecs_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ecs_pkg::S_DECODE;
                end
            end
            ecs_pkg::S_DECODE: begin
                case (i_sts.kind)
                    ecs_pkg::KIND_TICK: begin
                        if (!i_sts.goal_zero) begin
                            n_state = ecs_pkg::S_REMC;
                        end else begin
                            o_cmd.pop_c = 1'b1;
                            n_state = ecs_pkg::S_POPC_W;
                        end
                    end
                    ecs_pkg::KIND_CABIN, ecs_pkg::KIND_HALL: begin
                        o_cmd.act = ecs_pkg::ACT_IDLE;
                        if (i_sts.out_free) begin
                            o_cmd.load_out = 1'b1;
                            n_state = ecs_pkg::S_IDLE;
                            if (i_sts.floor_ok) begin
                                if ((i_sts.kind == ecs_pkg::KIND_CABIN) ? i_sts.c_full
                                                                        : i_sts.h_full) begin
                                    o_cmd.dropped = 1'b1;
                                end else begin
                                    o_cmd.act    = ecs_pkg::ACT_CALL;
                                    o_cmd.push_c = i_sts.kind == ecs_pkg::KIND_CABIN;
                                    o_cmd.push_h = i_sts.kind == ecs_pkg::KIND_HALL;
                                end
                            end
                        end
                    end
                    default: begin
                        o_cmd.act = ecs_pkg::ACT_IDLE;
                        if (i_sts.out_free) begin
                            o_cmd.load_out = 1'b1;
                            n_state = ecs_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            ecs_pkg::S_POPC_W: begin
                if (i_sts.c_done) begin
                    if (i_sts.c_hit) begin
                        o_cmd.goal_c = 1'b1;
                        n_state = ecs_pkg::S_REMC;
                    end else begin
                        o_cmd.pop_h = 1'b1;
                        n_state = ecs_pkg::S_POPH_W;
                    end
                end
            end
            ecs_pkg::S_POPH_W: begin
                if (i_sts.h_done) begin
                    if (i_sts.h_hit) begin
                        o_cmd.goal_h = 1'b1;
                        n_state = ecs_pkg::S_REMC;
                    end else begin
                        n_state = ecs_pkg::S_FIN;
                        n_hit   = 1'b0;
                        n_arr   = 1'b0;
                    end
                end
            end
            ecs_pkg::S_REMC: begin
                o_cmd.rem_c = 1'b1;
                n_state = ecs_pkg::S_REMC_W;
            end
            ecs_pkg::S_REMC_W: begin
                if (i_sts.c_done) begin
                    if (i_sts.c_hit) begin
                        n_hit   = 1'b1;
                        n_state = ecs_pkg::S_ARRIVE;
                    end else begin
                        o_cmd.rem_h = 1'b1;
                        n_state = ecs_pkg::S_REMH_W;
                    end
                end
            end
            ecs_pkg::S_REMH_W: begin
                if (i_sts.h_done) begin
                    n_hit   = i_sts.h_hit;
                    n_state = ecs_pkg::S_ARRIVE;
                end
            end
            ecs_pkg::S_ARRIVE: begin
                n_arr = i_sts.arrived;
                if (i_sts.arrived) begin
                    o_cmd.pop_c = 1'b1;
                    n_state = ecs_pkg::S_NPC_W;
                end else begin
                    n_state = ecs_pkg::S_STEP;
                end
            end
            ecs_pkg::S_NPC_W: begin
                if (i_sts.c_done) begin
                    if (i_sts.c_hit) begin
                        o_cmd.goal_c = 1'b1;
                        n_state = ecs_pkg::S_STEP;
                    end else begin
                        o_cmd.pop_h = 1'b1;
                        n_state = ecs_pkg::S_NPH_W;
                    end
                end
            end
            ecs_pkg::S_NPH_W: begin
                if (i_sts.h_done) begin
                    if (i_sts.h_hit) begin
                        o_cmd.goal_h = 1'b1;
                        n_state = ecs_pkg::S_STEP;
                    end else begin
                        o_cmd.goal_clr = 1'b1;
                        n_state = ecs_pkg::S_FIN;
                    end
                end
            end
            ecs_pkg::S_STEP: begin
                if (i_sts.out_free) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state = ecs_pkg::S_IDLE;
                end
            end
            ecs_pkg::S_FIN: begin
                if (!r_hit && !r_arr) begin
                    o_cmd.act = ecs_pkg::ACT_IDLE;
                end
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ecs_pkg::S_IDLE;
                end
            end
            default: n_state = ecs_pkg::S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/elevator_call_scheduler.sv =====
// Elevator call scheduler: takes one item at a time (floor tick, cabin call or
// hall call) and returns exactly one result item per input item. Calls go into
// two queues of QUEUE_DEPTH entries held in registers; a tick pops a target when
// none is held, removes the first queued call for the current floor (cabin queue
// first), reports a stop or a pass, and steps the cabin one floor toward its
// target unless it has arrived with no further call; with no target and no
// queued call it reports idle. Each queue operation a tick needs (pop a target,
// remove from the cabin queue, remove from the hall queue, pop the next target)
// is one pass that scans up to the match and then shifts the entries behind it
// down, one entry a cycle. The next item is taken once the controller is back
// in idle; a finished result waits in the output register and only holds the
// block when a second result is due.
// Writing start_floor (saturated into 1 to MAX_FLOOR) moves the cabin at once;
// write it only while the block is idle.
module elevator_call_scheduler #(
    parameter int MAX_FLOOR   = ecs_pkg::MAX_FLOOR_DEF,
    parameter int QUEUE_DEPTH = ecs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  ecs_pkg::t_in_item           i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output ecs_pkg::t_out_item          o_item,
    input  logic                        i_cfg_we,
    input  logic [ecs_pkg::FLOOR_W-1:0] i_cfg_data
);
    ecs_pkg::t_cmd cmd;
    ecs_pkg::t_sts sts;

    // Sequence each item through the queue operations.
    ecs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold queues, position, target and the output register.
    ecs_dp #(
        .MAX_FLOOR   (MAX_FLOOR),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out_item  (o_item)
    );
endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_FLOOR  = ecs_pkg::MAX_FLOOR_DEF;
    localparam int DEPTH      = ecs_pkg::QUEUE_DEPTH_DEF;
    localparam int FW         = ecs_pkg::FLOOR_W;
    localparam int N_RANDOM   = 1800;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 400;

    // Unused kind value, ignored by the block.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Idling phases: none, sender idle, receiver stalling, both.
    localparam int PH_NONE = 0;
    localparam int PH_SEND = 1;
    localparam int PH_RECV = 2;
    localparam int PH_BOTH = 3;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    ecs_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_stall;
    ecs_pkg::t_out_item o_item;
    logic               i_cfg_we;
    logic [FW-1:0]      i_cfg_data;

    elevator_call_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted cabin state: two call queues, position and target.
    logic [FW-1:0] cabin_q[$];
    logic [FW-1:0] hall_q[$];
    logic [FW-1:0] cab_pos;
    logic [FW-1:0] cab_goal;

    ecs_pkg::t_out_item due_results[$];
    int        n_fail;
    int        n_checked;
    int        n_stops;
    int        n_drops;
    int        cycle_no = 0;
    int        phase;
    int        hold_off = 0;
    bit        hold_req = 1'b0;
    bit        hold_used = 1'b0;

    function automatic bit take_call(ref logic [FW-1:0] q[$], input logic [FW-1:0] f);
        for (int i = 0; i < q.size(); i++) begin
            if (q[i] == f) begin
                q.delete(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Load the next target, cabin calls first; clear it when nothing is queued.
    function automatic bit pick_goal();
        if (cabin_q.size() > 0) begin
            cab_goal = cabin_q.pop_front();
            return 1'b1;
        end
        if (hall_q.size() > 0) begin
            cab_goal = hall_q.pop_front();
            return 1'b1;
        end
        cab_goal = '0;
        return 1'b0;
    endfunction

    function automatic ecs_pkg::t_out_item predict_move(ecs_pkg::t_in_item it);
        ecs_pkg::t_out_item r;
        bit have;
        bit hit;
        bit arrived;
        r.action       = ecs_pkg::ACT_IDLE;
        r.floor        = cab_pos;
        r.call_dropped = 1'b0;
        if (it.kind == ecs_pkg::KIND_CABIN || it.kind == ecs_pkg::KIND_HALL) begin
            if (it.call_floor >= 1 && it.call_floor <= TOP_FLOOR) begin
                if (it.kind == ecs_pkg::KIND_CABIN) begin
                    if (cabin_q.size() < DEPTH) begin
                        cabin_q.push_back(it.call_floor);
                        r.action = ecs_pkg::ACT_CALL;
                    end else begin
                        r.call_dropped = 1'b1;
                    end
                end else begin
                    if (hall_q.size() < DEPTH) begin
                        hall_q.push_back(it.call_floor);
                        r.action = ecs_pkg::ACT_CALL;
                    end else begin
                        r.call_dropped = 1'b1;
                    end
                end
            end
        end else if (it.kind == ecs_pkg::KIND_TICK) begin
            have = (cab_goal != 0) || pick_goal();
            if (have) begin
                hit = take_call(cabin_q, cab_pos);
                if (!hit) hit = take_call(hall_q, cab_pos);
                arrived = (cab_goal == cab_pos);
                r.action = (hit || arrived) ? ecs_pkg::ACT_STOP : ecs_pkg::ACT_PASS;
                if (!arrived || pick_goal()) begin
                    if (cab_pos < cab_goal) cab_pos = cab_pos + 1'b1;
                    else if (cab_pos > cab_goal) cab_pos = cab_pos - 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Idle a while if the phase asks for it, offer the item, wait for it to be
    // taken, then queue its prediction. Valid stays high after the accept
    // until the next idle gap or drain drops it.
    task automatic send_item(ecs_pkg::t_in_item it);
        if (phase == PH_SEND || phase == PH_BOTH) begin
            while ($urandom_range(99) < 53) begin
                i_valid <= 1'b0;
                i_item  <= ecs_pkg::t_in_item'($urandom);
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        due_results.push_back(predict_move(it));
    endtask

    // Same, but also check a typed-in result against the prediction.
    task automatic send_known(ecs_pkg::t_in_item it, ecs_pkg::t_out_item known);
        send_item(it);
        if (due_results[$] !== known) begin
            $display("%0t: table row mismatch, expected %h actual prediction %h",
                     $realtime, known, due_results[$]);
            n_fail++;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (due_results.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Write start_floor while idle; hold the model position in step.
    task automatic set_start(logic [FW-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (v < 1) cab_pos = 1;
        else if (v > TOP_FLOOR) cab_pos = TOP_FLOOR;
        else cab_pos = v;
    endtask

    function automatic ecs_pkg::t_in_item rand_item();
        ecs_pkg::t_in_item it;
        int r;
        r = $urandom_range(99);
        if (r < 50) it.kind = ecs_pkg::KIND_TICK;
        else if (r < 72) it.kind = ecs_pkg::KIND_CABIN;
        else if (r < 94) it.kind = ecs_pkg::KIND_HALL;
        else it.kind = KIND_SPARE;
        // mostly legal floors, sometimes zero or beyond the top
        if ($urandom_range(9) == 0) it.call_floor = FW'($urandom);
        else it.call_floor = FW'($urandom_range(TOP_FLOOR, 1));
        return it;
    endfunction

    // Receiver: random stalls per phase, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off > 0) begin
            i_stall  <= 1'b1;
            hold_off <= hold_off - 1;
        end else if (hold_req && !hold_used) begin
            i_stall   <= 1'b1;
            hold_off  <= 600;
            hold_used <= 1'b1;
        end else if (phase == PH_RECV || phase == PH_BOTH) begin
            i_stall <= ($urandom_range(99) < 53);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h",
                         $realtime, o_item);
                n_fail++;
            end else begin
                ecs_pkg::t_out_item want;
                want = due_results.pop_front();
                n_checked++;
                if (o_item.action == ecs_pkg::ACT_STOP) n_stops++;
                if (o_item.call_dropped) n_drops++;
                if (o_item.action !== want.action)
                    begin $display("%0t: action expected %0d actual %0d",
                             $realtime, want.action, o_item.action); n_fail++; end
                if (o_item.floor !== want.floor)
                    begin $display("%0t: floor expected %0d actual %0d",
                             $realtime, want.floor, o_item.floor); n_fail++; end
                if (o_item.call_dropped !== want.call_dropped)
                    begin $display("%0t: call_dropped expected %0d actual %0d",
                             $realtime, want.call_dropped, o_item.call_dropped);
                          n_fail++; end
            end
        end
    end

    // Watchdog: end the run on a stuck block.
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic ecs_pkg::t_in_item mk(logic [1:0] k, int f);
        ecs_pkg::t_in_item it;
        it.kind = k;
        it.call_floor = FW'(f);
        return it;
    endfunction

    function automatic ecs_pkg::t_out_item res(logic [1:0] a, int f, bit d);
        ecs_pkg::t_out_item r;
        r.action = a;
        r.floor = FW'(f);
        r.call_dropped = d;
        return r;
    endfunction

    typedef struct {
        ecs_pkg::t_in_item  stim;
        bit                 known;
        ecs_pkg::t_out_item want;
    } t_row;

    t_row dir_rows[$];

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        n_fail = 0; n_checked = 0; n_stops = 0; n_drops = 0;
        phase = PH_NONE;
        cab_pos = 1; cab_goal = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: idle after reset, ignored calls, extremes, stops.
        dir_rows.push_back('{mk(ecs_pkg::KIND_TICK, 0), 1, res(ecs_pkg::ACT_IDLE, 1, 0)});
        dir_rows.push_back('{mk(ecs_pkg::KIND_CABIN, 0), 1, res(ecs_pkg::ACT_IDLE, 1, 0)});
        dir_rows.push_back('{mk(ecs_pkg::KIND_HALL, 17), 1, res(ecs_pkg::ACT_IDLE, 1, 0)});
        dir_rows.push_back('{mk(ecs_pkg::KIND_CABIN, 31), 1, res(ecs_pkg::ACT_IDLE, 1, 0)});
        dir_rows.push_back('{mk(KIND_SPARE, 5), 1, res(ecs_pkg::ACT_IDLE, 1, 0)});
        dir_rows.push_back('{mk(ecs_pkg::KIND_CABIN, 16), 1, res(ecs_pkg::ACT_CALL, 1, 0)});
        dir_rows.push_back('{mk(ecs_pkg::KIND_HALL, 1), 1, res(ecs_pkg::ACT_CALL, 1, 0)});
        dir_rows.push_back('{mk(ecs_pkg::KIND_HALL, 3), 0, '0});
        for (int i = 0; i < 6; i++) dir_rows.push_back('{mk(ecs_pkg::KIND_TICK, 0), 0, '0});
        dir_rows.push_back('{mk(ecs_pkg::KIND_CABIN, 2), 0, '0});
        dir_rows.push_back('{mk(ecs_pkg::KIND_CABIN, 7), 0, '0});
        for (int i = 0; i < 8; i++) dir_rows.push_back('{mk(ecs_pkg::KIND_TICK, 0), 0, '0});
        foreach (dir_rows[i]) begin
            if (dir_rows[i].known) send_known(dir_rows[i].stim, dir_rows[i].want);
            else send_item(dir_rows[i].stim);
        end

        // Fill both queues past full to see calls dropped.
        set_start(5'd0);
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(mk(ecs_pkg::KIND_CABIN, (i % TOP_FLOOR) + 1));
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(mk(ecs_pkg::KIND_HALL, TOP_FLOOR - (i % TOP_FLOOR)));
        send_known(mk(ecs_pkg::KIND_CABIN, 4), res(ecs_pkg::ACT_IDLE, 1, 1));
        send_known(mk(ecs_pkg::KIND_HALL, 4), res(ecs_pkg::ACT_IDLE, 1, 1));
        set_start(5'd31);
        for (int i = 0; i < 60; i++) send_item(mk(ecs_pkg::KIND_TICK, 0));

        // Random part in idling phases with start floor changes in between.
        for (int p = 0; p < 8; p++) begin
            set_start((p % 3 == 0) ? 5'd16 : ((p % 3 == 1) ? 5'd1 : FW'($urandom)));
            phase = p % 4;
            // long receiver hold-off while items keep coming
            if (p == 5) hold_req = 1'b1;
            for (int i = 0; i < N_RANDOM / 8; i++) send_item(rand_item());
            if (p == 6) drain();
        end
        phase = PH_NONE;

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Checked %0d results (%0d stops, %0d dropped calls) over 8 phases",
                 n_checked, n_stops, n_drops);
        $display("with start floor writes at both ends and a long output hold-off.");
        if (n_fail == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (due_results.size() != 0)
                $display("%0t: %0d results never arrived", $realtime, due_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/ecs_pkg.sv
hw/rtl/ecs_queue.sv
hw/rtl/ecs_dp.sv
hw/rtl/ecs_ctrl.sv
hw/rtl/elevator_call_scheduler.sv
sim/testbench.sv
